/* design/slsc_pkg.sv */
// ----------------------------------------------------------------------------
// slsc_pkg
// Shared constants of the staged light sequencer: limits, register indexes,
// reset values, action codes and port widths.
// ----------------------------------------------------------------------------
package slsc_pkg;

	localparam int unsigned MAX_STAGES     = 16;
	localparam int unsigned MAX_STAGE_LEDS = 64;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STAGE_DUR    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_STAGES   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEDS_PER_STG = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_COLOR  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MIDDLE_COLOR = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LAST_COLOR   = 3'd6;

	localparam logic [10:0] RST_THRESHOLD    = 11'd1600;
	localparam logic [15:0] RST_STAGE_DUR    = 16'd500;
	localparam logic [4:0]  RST_NUM_STAGES   = 5'd3;
	localparam logic [6:0]  RST_LEDS_PER_STG = 7'd8;
	localparam logic [23:0] RST_FIRST_COLOR  = 24'hFFBF00;
	localparam logic [23:0] RST_MIDDLE_COLOR = 24'hFFBF00;
	localparam logic [23:0] RST_LAST_COLOR   = 24'h00FF00;

	localparam logic ACT_CLEAR = 1'b0;
	localparam logic ACT_FILL  = 1'b1;

	localparam int unsigned IN_DATA_W  = 56;
	localparam int unsigned OUT_DATA_W = 48;

	// stage bounds reach 17 * 65535 and the retrigger limit 2 * 16 * 65535
	localparam int unsigned BOUND_W = 21;

endpackage

/* design/staged_light_sequencer_core.sv */
// ----------------------------------------------------------------------------
// staged_light_sequencer_core
// Control pass engine for a staged light sequence: switch thresholds, mode and
// trigger tracking, auto retrigger and a stage search over one shared adder.
// ----------------------------------------------------------------------------
// flow: accept, mode and trigger update, auto retrigger check, then a stage search
//   of n = 1 to stage count + 1 steps on the shared add and compare unit, then the results
// passes: one at a time; a new input is accepted only when idle, a stalled output holds the pass
// reset: mode, trigger and done state to their idle values, config registers
//   to their defaults, output channel empty
// ----------------------------------------------------------------------------
module staged_light_sequencer_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// time_ms[31:0], mode_ch[42:32], trig_ch[53:43], zero pad
	input  logic [slsc_pkg::IN_DATA_W-1:0]        s_tdata,
	// packet_valid
	input  logic                                  s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// fill_color[23:0], fill_top[33:24], fill_count[40:34], zero pad
	output logic [slsc_pkg::OUT_DATA_W-1:0]       m_tdata,
	// action
	output logic                                  m_tuser,
	// last_of_pass
	output logic                                  m_tlast,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [slsc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [slsc_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MODE = 3'd1;
	localparam logic [2:0] S_AUTO = 3'd2;
	localparam logic [2:0] S_SRCH = 3'd3;
	localparam logic [2:0] S_OUT1 = 3'd4;
	localparam logic [2:0] S_OUT2 = 3'd5;

	localparam int unsigned BW = slsc_pkg::BOUND_W;

	// configuration
	logic [10:0] thr_q;
	logic [15:0] dur_q;
	logic [4:0]  nstg_q;
	logic [6:0]  lps_cfg_q;
	logic [23:0] col_first_q;
	logic [23:0] col_mid_q;
	logic [23:0] col_last_q;

	// sequencer
	logic [2:0]  state_q;
	logic [31:0] now_q;
	logic        pkt_q;
	logic [10:0] mch_q;
	logic [10:0] tch_q;
	logic [4:0]  ns_q;
	logic [6:0]  lps_q;
	logic [19:0] tot_q;
	logic [BW-1:0] lo_q;
	logic [4:0]  idx_q;
	logic [4:0]  stage_q;
	logic        clr_q;
	logic        fill_q;
	logic        endclr_q;
	logic [9:0]  top_q;

	// persistent pass state
	logic        manual_q;
	logic        held_q;
	logic [31:0] start_q;
	logic        done_q;

	// output register
	logic                            out_valid_q;
	logic [slsc_pkg::OUT_DATA_W-1:0] out_data_q;
	logic                            out_user_q;
	logic                            out_last_q;

	logic        out_free;
	logic        out_push;
	logic        accept;
	logic [4:0]  ns_clamp;
	logic [6:0]  lps_clamp;
	logic        nm;
	logic        nt;
	logic        m_next;
	logic        h_next;
	logic [31:0] st_next;
	logic        d_next;
	logic        clr_next;
	logic [31:0] elapsed;
	logic [BW-1:0] hi;
	logic        hit;
	logic        active;
	logic [4:0]  ns_minus_stage;
	logic [11:0] top_prod;
	logic [23:0] fill_col;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign out_push  = ((state_q == S_OUT1) && clr_q && out_free)
		|| ((state_q == S_OUT2) && out_free);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;
	assign m_tlast  = out_last_q;

	always_comb begin
		if (nstg_q == 5'd0) begin
			ns_clamp = 5'd1;
		end else if ({27'd0, nstg_q} > slsc_pkg::MAX_STAGES) begin
			ns_clamp = 5'(slsc_pkg::MAX_STAGES);
		end else begin
			ns_clamp = nstg_q;
		end
		if (lps_cfg_q == 7'd0) begin
			lps_clamp = 7'd1;
		end else if ({25'd0, lps_cfg_q} > slsc_pkg::MAX_STAGE_LEDS) begin
			lps_clamp = 7'(slsc_pkg::MAX_STAGE_LEDS);
		end else begin
			lps_clamp = lps_cfg_q;
		end
	end

	// mode and trigger tracking for a pass with fresh channel values
	always_comb begin
		nm       = mch_q > thr_q;
		nt       = tch_q > thr_q;
		m_next   = manual_q;
		h_next   = held_q;
		st_next  = start_q;
		d_next   = done_q;
		clr_next = 1'b0;
		if (pkt_q && ((nm != manual_q) || (nt != held_q))) begin
			if (!nm && manual_q) begin
				clr_next = 1'b1;
				st_next  = now_q;
				d_next   = 1'b1;
			end
			if (nm && !manual_q) begin
				clr_next = 1'b1;
				st_next  = 32'd0;
				d_next   = 1'b1;
			end
			if (nm && nt && !held_q) begin
				st_next = now_q;
				d_next  = 1'b0;
			end
			if (manual_q && held_q && !nt) begin
				clr_next = 1'b1;
				d_next   = 1'b1;
			end
			m_next = nm;
			h_next = nt;
		end
	end

	// shared add and compare unit
	assign elapsed = now_q - start_q;
	assign hi      = lo_q + {{(BW-16){1'b0}}, dur_q};
	assign hit     = ({{(32-BW){1'b0}}, lo_q} < elapsed) && (elapsed < {{(32-BW){1'b0}}, hi});
	assign active  = held_q && !done_q;

	assign ns_minus_stage = ns_q - stage_q;
	assign top_prod       = 12'({7'd0, ns_minus_stage} * {5'd0, lps_q});

	always_comb begin
		if (stage_q == 5'd0) begin
			fill_col = col_first_q;
		end else if (stage_q < ns_q - 5'd1) begin
			fill_col = col_mid_q;
		end else begin
			fill_col = col_last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= slsc_pkg::RST_THRESHOLD;
			dur_q       <= slsc_pkg::RST_STAGE_DUR;
			nstg_q      <= slsc_pkg::RST_NUM_STAGES;
			lps_cfg_q   <= slsc_pkg::RST_LEDS_PER_STG;
			col_first_q <= slsc_pkg::RST_FIRST_COLOR;
			col_mid_q   <= slsc_pkg::RST_MIDDLE_COLOR;
			col_last_q  <= slsc_pkg::RST_LAST_COLOR;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				slsc_pkg::REG_THRESHOLD:    thr_q       <= cfg_data[10:0];
				slsc_pkg::REG_STAGE_DUR:    dur_q       <= cfg_data[15:0];
				slsc_pkg::REG_NUM_STAGES:   nstg_q      <= cfg_data[4:0];
				slsc_pkg::REG_LEDS_PER_STG: lps_cfg_q   <= cfg_data[6:0];
				slsc_pkg::REG_FIRST_COLOR:  col_first_q <= cfg_data;
				slsc_pkg::REG_MIDDLE_COLOR: col_mid_q   <= cfg_data;
				slsc_pkg::REG_LAST_COLOR:   col_last_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			manual_q    <= 1'b0;
			held_q      <= 1'b0;
			start_q     <= 32'd0;
			done_q      <= 1'b1;
			clr_q       <= 1'b0;
			fill_q      <= 1'b0;
			endclr_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_push) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_MODE;
					end
				end
				S_MODE: begin
					manual_q <= m_next;
					held_q   <= h_next;
					start_q  <= st_next;
					done_q   <= d_next;
					clr_q    <= clr_next;
					state_q  <= S_AUTO;
				end
				S_AUTO: begin
					fill_q   <= 1'b0;
					endclr_q <= 1'b0;
					if (!manual_q && done_q && (elapsed > {11'd0, tot_q, 1'b0})) begin
						clr_q   <= 1'b1;
						start_q <= now_q;
						done_q  <= 1'b0;
						held_q  <= 1'b1;
					end
					state_q <= S_SRCH;
				end
				S_SRCH: begin
					if (!active) begin
						state_q <= S_OUT1;
					end else if (hit) begin
						if (idx_q < ns_q) begin
							fill_q <= 1'b1;
						end else begin
							endclr_q <= !clr_q;
							done_q   <= 1'b1;
							held_q   <= 1'b0;
						end
						state_q <= S_OUT1;
					end else if (idx_q == ns_q) begin
						state_q <= S_OUT1;
					end
				end
				S_OUT1: begin
					if (!clr_q) begin
						state_q <= (fill_q || endclr_q) ? S_OUT2 : S_IDLE;
					end else if (out_free) begin
						state_q <= (fill_q || endclr_q) ? S_OUT2 : S_IDLE;
					end
				end
				S_OUT2: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			now_q <= s_tdata[31:0];
			mch_q <= s_tdata[42:32];
			tch_q <= s_tdata[53:43];
			pkt_q <= s_tuser;
			ns_q  <= ns_clamp;
			lps_q <= lps_clamp;
		end
		if (state_q == S_MODE) begin
			tot_q <= 20'({15'd0, ns_q} * {4'd0, dur_q});
		end
		if (state_q == S_AUTO) begin
			lo_q  <= '0;
			idx_q <= 5'd0;
		end
		if (state_q == S_SRCH) begin
			lo_q    <= hi;
			idx_q   <= idx_q + 5'd1;
			stage_q <= idx_q;
		end
		if (state_q == S_OUT1) begin
			top_q <= 10'(top_prod - 12'd1);
			if (clr_q && out_free) begin
				out_data_q <= '0;
				out_user_q <= slsc_pkg::ACT_CLEAR;
				out_last_q <= !(fill_q || endclr_q);
			end
		end
		if ((state_q == S_OUT2) && out_free) begin
			out_last_q <= 1'b1;
			if (fill_q) begin
				out_user_q <= slsc_pkg::ACT_FILL;
				out_data_q <= {7'd0, lps_q, top_q, fill_col};
			end else begin
				out_user_q <= slsc_pkg::ACT_CLEAR;
				out_data_q <= '0;
			end
		end
	end

endmodule

/* design/slsc_checker.sv */
// ----------------------------------------------------------------------------
// slsc_checker
// Port level checks of the staged light sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module slsc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [slsc_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic                            m_tuser,
	input logic                            m_tlast
);

	// a pass is processed alone
	a_one_pass: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while a pass is in progress");

	// a clear carries no color, top or count
	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == slsc_pkg::ACT_CLEAR) |-> (m_tdata == '0))
		else $error("clear transaction with nonzero payload");

	// a fill always closes its pass and lights at least one led
	a_fill_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == slsc_pkg::ACT_FILL) |-> m_tlast && (m_tdata[40:34] != 7'd0))
		else $error("fill transaction not last or empty");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output transaction changed under stall");

endmodule

bind staged_light_sequencer_core slsc_checker u_slsc_checker (.*);
